// File: sv/lavm_pkg.sv
// Shared types, widths, row codes and rounding helpers of the look-at view matrix unit.
// Depends on nothing; every other file of the unit imports it.
`default_nettype none

package lavm_pkg;

    localparam int COORD_W   = 32;              // input and output coordinate width
    localparam int FRAC_BITS = 16;              // fraction bits of the fixed-point format
    localparam int UNIT_W    = FRAC_BITS + 2;   // signed unit-vector component
    localparam int QUOT_W    = FRAC_BITS + 1;   // magnitude of a unit component
    localparam int VEC_W     = 64;              // normalizer input component
    localparam int MAG_W     = VEC_W - 1;       // magnitude of a normalizer input
    localparam int POS_W     = 6;               // bit position within MAG_W
    localparam int NORM_MSB  = 29;              // scaled maximum lies in [2^29, 2^30)
    localparam int SCL_W     = NORM_MSB + 1;
    localparam int SQ_W      = 2 * SCL_W;
    localparam int SUM_W     = SQ_W + 2;
    localparam int SQ_STEPS  = SUM_W / 2;       // one result bit of the root per step
    localparam int LEN_W     = COORD_W;
    localparam int REM_W     = FRAC_BITS + LEN_W + 1;

    localparam logic [1:0] ROW_SIDE = 2'd0;
    localparam logic [1:0] ROW_UP   = 2'd1;
    localparam logic [1:0] ROW_FWD  = 2'd2;

    localparam logic signed [VEC_W-1:0] SAT_MAX =
        {{(VEC_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    localparam logic signed [VEC_W-1:0] SAT_MIN =
        {{(VEC_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

    typedef logic signed [COORD_W-1:0] coord_t;

    // Sideband that rides along with a vector through the normalizer.
    typedef struct packed {
        logic [2:0][COORD_W-1:0] eye;
        logic [2:0][COORD_W-1:0] up;
        logic [2:0][UNIT_W-1:0]  fwd;
        logic                    bad;
    } side_t;

    // Shift right by FRAC_BITS, rounding half away from zero.
    function automatic logic signed [VEC_W-1:0] shr_rnd(input logic signed [VEC_W-1:0] v);
        logic [VEC_W-1:0] m;
        logic [VEC_W-1:0] r;
        m = v[VEC_W-1] ? VEC_W'(-v) : VEC_W'(v);
        r = (m + (VEC_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        return v[VEC_W-1] ? -$signed(r) : $signed(r);
    endfunction

    // Clamp to the signed coordinate range.
    function automatic logic [COORD_W-1:0] sat32(input logic signed [VEC_W-1:0] v);
        logic signed [VEC_W-1:0] c;
        c = v;
        if (v > SAT_MAX) c = SAT_MAX;
        if (v < SAT_MIN) c = SAT_MIN;
        return c[COORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: sv/lavm_ifs.sv
// Valid/ready channel interfaces of the look-at view matrix unit.
// Depends on lavm_pkg for the coordinate type.
`default_nettype none

interface lavm_in_if;
    logic            valid;
    logic            ready;
    lavm_pkg::coord_t eye_x;
    lavm_pkg::coord_t eye_y;
    lavm_pkg::coord_t eye_z;
    lavm_pkg::coord_t target_x;
    lavm_pkg::coord_t target_y;
    lavm_pkg::coord_t target_z;
    lavm_pkg::coord_t up_x;
    lavm_pkg::coord_t up_y;
    lavm_pkg::coord_t up_z;

    modport source (output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                    up_x, up_y, up_z, input ready);
    modport sink   (input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                    up_x, up_y, up_z, output ready);
endinterface

interface lavm_out_if;
    logic             valid;
    logic             ready;
    logic [1:0]       row_index;
    lavm_pkg::coord_t col0;
    lavm_pkg::coord_t col1;
    lavm_pkg::coord_t col2;
    lavm_pkg::coord_t col3;
    logic             degenerate;
    logic             last_row;

    modport source (output valid, row_index, col0, col1, col2, col3, degenerate, last_row,
                    input ready);
    modport sink   (input valid, row_index, col0, col1, col2, col3, degenerate, last_row,
                    output ready);
endinterface

`default_nettype wire

// File: sv/lavm_norm.sv
// Pipelined normalizer of a three-component vector: scale, sum of squares, bit-serial
// square root and restoring division, one step per stage. Depends on lavm_pkg.
`default_nettype none

module lavm_norm (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [2:0][lavm_pkg::VEC_W-1:0]     vec,
    input  lavm_pkg::side_t                     in_side,
    output logic                                out_valid,
    output logic [2:0][lavm_pkg::UNIT_W-1:0]    unit,
    output logic                                ok,
    output lavm_pkg::side_t                     out_side
);
    import lavm_pkg::*;

    typedef struct packed {
        side_t                   side;
        logic                    zero;
        logic [2:0]              neg;
        logic [2:0][SCL_W-1:0]   ms;
    } sq_carry_t;

    typedef struct packed {
        side_t      side;
        logic       zero;
        logic [2:0] neg;
    } dv_carry_t;

    // Stage A: magnitudes and signs.
    logic                    a_valid_reg;
    logic [2:0][MAG_W-1:0]   a_mag_reg, a_mag_next;
    logic [2:0]              a_neg_reg, a_neg_next;
    side_t                   a_side_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_neg_next[i] = vec[i][VEC_W-1];
            a_mag_next[i] = vec[i][VEC_W-1] ? MAG_W'(-vec[i]) : MAG_W'(vec[i]);
        end
    end

    // Stage B: position of the leading one of the largest magnitude.
    logic                    b_valid_reg;
    logic [MAG_W-1:0]        a_or;
    logic [POS_W-1:0]        b_pos_reg, b_pos_next;
    logic                    b_zero_reg;
    logic [2:0][MAG_W-1:0]   b_mag_reg;
    logic [2:0]              b_neg_reg;
    side_t                   b_side_reg;

    always_comb
    begin
        a_or = a_mag_reg[0] | a_mag_reg[1] | a_mag_reg[2];
        b_pos_next = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (a_or[i])
                b_pos_next = POS_W'(i);
        end
    end

    // Stage C: scale so the largest magnitude lies in [2^NORM_MSB, 2^(NORM_MSB+1)).
    logic       c_valid_reg;
    sq_carry_t  c_cr_reg, c_cr_next;

    always_comb
    begin
        c_cr_next.side = b_side_reg;
        c_cr_next.zero = b_zero_reg;
        c_cr_next.neg  = b_neg_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (b_pos_reg >= POS_W'(NORM_MSB))
                c_cr_next.ms[i] = SCL_W'(b_mag_reg[i] >> (b_pos_reg - POS_W'(NORM_MSB)));
            else
                c_cr_next.ms[i] = SCL_W'(b_mag_reg[i] << (POS_W'(NORM_MSB) - b_pos_reg));
        end
    end

    // Stage D: squares.
    logic                   d_valid_reg;
    logic [2:0][SQ_W-1:0]   d_sq_reg, d_sq_next;
    sq_carry_t              d_cr_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            d_sq_next[i] = SQ_W'(c_cr_reg.ms[i]) * SQ_W'(c_cr_reg.ms[i]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_mag_reg  <= a_mag_next;
            a_neg_reg  <= a_neg_next;
            a_side_reg <= in_side;
            b_pos_reg  <= b_pos_next;
            b_zero_reg <= (a_or == '0);
            b_mag_reg  <= a_mag_reg;
            b_neg_reg  <= a_neg_reg;
            b_side_reg <= a_side_reg;
            c_cr_reg   <= c_cr_next;
            d_sq_reg   <= d_sq_next;
            d_cr_reg   <= c_cr_reg;
        end
    end

    // Square root stages; entry 0 holds the sum of squares.
    logic              sq_valid_reg [SQ_STEPS+1];
    logic [SUM_W-1:0]  sq_n_reg     [SQ_STEPS+1];
    logic [SUM_W-1:0]  sq_res_reg   [SQ_STEPS+1];
    sq_carry_t         sq_cr_reg    [SQ_STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_valid_reg[0] <= 1'b0;
        else if (en)
            sq_valid_reg[0] <= d_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_n_reg[0]   <= SUM_W'(d_sq_reg[0]) + SUM_W'(d_sq_reg[1]) + SUM_W'(d_sq_reg[2]);
            sq_res_reg[0] <= '0;
            sq_cr_reg[0]  <= d_cr_reg;
        end
    end

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sq
        localparam int SH = SUM_W - 2 - 2 * k;
        logic [SUM_W-1:0] sq_bit;
        logic [SUM_W-1:0] sq_trial;
        logic [SUM_W-1:0] sq_n_next;
        logic [SUM_W-1:0] sq_res_next;

        always_comb
        begin
            sq_bit   = SUM_W'(1) << SH;
            sq_trial = sq_res_reg[k] + sq_bit;
            if (sq_n_reg[k] >= sq_trial)
            begin
                sq_n_next   = sq_n_reg[k] - sq_trial;
                sq_res_next = (sq_res_reg[k] >> 1) + sq_bit;
            end
            else
            begin
                sq_n_next   = sq_n_reg[k];
                sq_res_next = sq_res_reg[k] >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_valid_reg[k+1] <= 1'b0;
            else if (en)
                sq_valid_reg[k+1] <= sq_valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_n_reg[k+1]   <= sq_n_next;
                sq_res_reg[k+1] <= sq_res_next;
                sq_cr_reg[k+1]  <= sq_cr_reg[k];
            end
        end
    end

    // Division stages; entry 0 holds the rounded dividends.
    logic                   dv_valid_reg [QUOT_W+1];
    logic [2:0][REM_W-1:0]  dv_r_reg     [QUOT_W+1];
    logic [2:0][QUOT_W-1:0] dv_q_reg     [QUOT_W+1];
    logic [LEN_W-1:0]       dv_len_reg   [QUOT_W+1];
    dv_carry_t              dv_cr_reg    [QUOT_W+1];
    logic [LEN_W-1:0]       sq_len;

    assign sq_len = sq_res_reg[SQ_STEPS][LEN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_valid_reg[0] <= 1'b0;
        else if (en)
            dv_valid_reg[0] <= sq_valid_reg[SQ_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                dv_r_reg[0][i] <= (REM_W'(sq_cr_reg[SQ_STEPS].ms[i]) << FRAC_BITS)
                                  + REM_W'(sq_len >> 1);
            dv_q_reg[0]       <= '0;
            dv_len_reg[0]     <= sq_len;
            dv_cr_reg[0].side <= sq_cr_reg[SQ_STEPS].side;
            dv_cr_reg[0].zero <= sq_cr_reg[SQ_STEPS].zero;
            dv_cr_reg[0].neg  <= sq_cr_reg[SQ_STEPS].neg;
        end
    end

    for (genvar j = 0; j < QUOT_W; j++)
    begin : g_dv
        localparam int QB = QUOT_W - 1 - j;
        logic [REM_W-1:0]        dv_sub;
        logic [2:0][REM_W-1:0]   dv_r_next;
        logic [2:0][QUOT_W-1:0]  dv_q_next;

        always_comb
        begin
            dv_sub = REM_W'(dv_len_reg[j]) << QB;
            for (int i = 0; i < 3; i++)
            begin
                dv_q_next[i] = dv_q_reg[j][i];
                if (dv_r_reg[j][i] >= dv_sub)
                begin
                    dv_r_next[i]     = dv_r_reg[j][i] - dv_sub;
                    dv_q_next[i][QB] = 1'b1;
                end
                else
                begin
                    dv_r_next[i] = dv_r_reg[j][i];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[j+1] <= 1'b0;
            else if (en)
                dv_valid_reg[j+1] <= dv_valid_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_r_reg[j+1]   <= dv_r_next;
                dv_q_reg[j+1]   <= dv_q_next;
                dv_len_reg[j+1] <= dv_len_reg[j];
                dv_cr_reg[j+1]  <= dv_cr_reg[j];
            end
        end
    end

    // Output stage: apply signs; a zero vector yields zeros and ok low.
    logic                     o_valid_reg;
    logic [2:0][UNIT_W-1:0]   o_unit_reg, o_unit_next;
    logic                     o_ok_reg;
    side_t                    o_side_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dv_cr_reg[QUOT_W].zero)
                o_unit_next[i] = '0;
            else if (dv_cr_reg[QUOT_W].neg[i])
                o_unit_next[i] = UNIT_W'(-UNIT_W'(dv_q_reg[QUOT_W][i]));
            else
                o_unit_next[i] = UNIT_W'(dv_q_reg[QUOT_W][i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (en)
            o_valid_reg <= dv_valid_reg[QUOT_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_unit_reg <= o_unit_next;
            o_ok_reg   <= !dv_cr_reg[QUOT_W].zero;
            o_side_reg <= dv_cr_reg[QUOT_W].side;
        end
    end

    assign out_valid = o_valid_reg;
    assign unit      = o_unit_reg;
    assign ok        = o_ok_reg;
    assign out_side  = o_side_reg;

endmodule

`default_nettype wire

// File: sv/look_at_view_matrix_unit.sv
// Top level of the look-at view matrix unit: input stages, two normalizers, cross and
// dot product stages and the row serializer. Depends on lavm_pkg, lavm_ifs, lavm_norm.
`default_nettype none

// The unit takes one transaction of eye, target and up vectors (signed Q16.16) and
// returns three row transactions of the right-handed view matrix: the side row, the
// up row and the negated forward row, each with its translation term in col3, in that
// order, with last_row set on the third. When target equals eye, or forward is
// parallel to up (or up is zero), all columns are zero and degenerate is set on all
// three rows. Every value saturates to the 32-bit range. The datapath is one long
// pipeline that moves as a whole: two normalizers, each with a one-bit-per-stage
// square root and a one-bit-per-stage divider, plus the product stages, lie
// between an accepted transaction and its first row. Items may enter back to
// back; the single output channel, showing one row per cycle while rows.ready is
// high, sets the sustained rate, as each item has three rows. The pipeline halts
// only when its last stage holds a finished item that the row serializer cannot
// yet take, so neither side loses or repeats a transaction under any stall pattern.

module look_at_view_matrix_unit (
    input  logic              clk,
    input  logic              rst_n,
    lavm_in_if.sink           vecs,
    lavm_out_if.source        rows
);
    import lavm_pkg::*;

    localparam int D_W   = COORD_W + 1;          // target minus eye
    localparam int PF_W  = UNIT_W + COORD_W;     // unit times coordinate
    localparam int C_W   = PF_W + 1;             // exact cross product
    localparam int SF_W  = 2 * UNIT_W;           // unit times unit
    localparam int C2_W  = SF_W + 1;
    localparam int DOT_W = PF_W + 2;
    localparam int U_W   = C2_W - FRAC_BITS + 1;
    localparam int T_W   = DOT_W - FRAC_BITS + 2;
    localparam int UE_W  = U_W + COORD_W;
    localparam int UES_W = UE_W + 2;

    logic adv;
    logic ser_free;
    logic ser_take;

    // Stage 1: register the transaction and form target minus eye.
    logic                     s1_valid_reg;
    logic [2:0][COORD_W-1:0]  s1_eye_reg;
    logic [2:0][COORD_W-1:0]  s1_up_reg;
    logic [2:0][D_W-1:0]      s1_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= vecs.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_eye_reg <= {vecs.eye_z, vecs.eye_y, vecs.eye_x};
            s1_up_reg  <= {vecs.up_z, vecs.up_y, vecs.up_x};
            s1_d_reg[0] <= D_W'(vecs.target_x) - D_W'(vecs.eye_x);
            s1_d_reg[1] <= D_W'(vecs.target_y) - D_W'(vecs.eye_y);
            s1_d_reg[2] <= D_W'(vecs.target_z) - D_W'(vecs.eye_z);
        end
    end

    // Forward vector.
    logic [2:0][VEC_W-1:0]   n1_vec;
    side_t                   n1_in_side;
    logic                    n1_valid;
    logic [2:0][UNIT_W-1:0]  n1_unit;
    logic                    n1_ok;
    side_t                   n1_side;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            n1_vec[i] = VEC_W'($signed(s1_d_reg[i]));
        n1_in_side.eye = s1_eye_reg;
        n1_in_side.up  = s1_up_reg;
        n1_in_side.fwd = '0;
        n1_in_side.bad = 1'b0;
    end

    lavm_norm u_norm_fwd (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s1_valid_reg),
        .vec       (n1_vec),
        .in_side   (n1_in_side),
        .out_valid (n1_valid),
        .unit      (n1_unit),
        .ok        (n1_ok),
        .out_side  (n1_side)
    );

    // Stage 2: products of forward cross up. Stage 3: the differences.
    logic                     s2_valid_reg;
    logic [2:0][PF_W-1:0]     s2_pa_reg, s2_pb_reg, s2_pa_next, s2_pb_next;
    logic [2:0][COORD_W-1:0]  s2_eye_reg;
    logic [2:0][UNIT_W-1:0]   s2_f_reg;
    logic                     s2_ok_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s2_pa_next[i] = PF_W'($signed(n1_unit[(i+1)%3]) * $signed(n1_side.up[(i+2)%3]));
            s2_pb_next[i] = PF_W'($signed(n1_side.up[(i+1)%3]) * $signed(n1_unit[(i+2)%3]));
        end
    end

    logic                     s3_valid_reg;
    logic [2:0][C_W-1:0]      s3_c_reg, s3_c_next;
    logic [2:0][COORD_W-1:0]  s3_eye_reg;
    logic [2:0][UNIT_W-1:0]   s3_f_reg;
    logic                     s3_ok_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            s3_c_next[i] = C_W'($signed(s2_pa_reg[i])) - C_W'($signed(s2_pb_reg[i]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= n1_valid;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_pa_reg  <= s2_pa_next;
            s2_pb_reg  <= s2_pb_next;
            s2_eye_reg <= n1_side.eye;
            s2_f_reg   <= n1_unit;
            s2_ok_reg  <= n1_ok;
            s3_c_reg   <= s3_c_next;
            s3_eye_reg <= s2_eye_reg;
            s3_f_reg   <= s2_f_reg;
            s3_ok_reg  <= s2_ok_reg;
        end
    end

    // Side vector.
    logic [2:0][VEC_W-1:0]   n2_vec;
    side_t                   n2_in_side;
    logic                    n2_valid;
    logic [2:0][UNIT_W-1:0]  n2_unit;
    logic                    n2_ok;
    side_t                   n2_side;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            n2_vec[i] = VEC_W'($signed(s3_c_reg[i]));
        n2_in_side.eye = s3_eye_reg;
        n2_in_side.up  = '0;
        n2_in_side.fwd = s3_f_reg;
        n2_in_side.bad = !s3_ok_reg;
    end

    lavm_norm u_norm_side (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s3_valid_reg),
        .vec       (n2_vec),
        .in_side   (n2_in_side),
        .out_valid (n2_valid),
        .unit      (n2_unit),
        .ok        (n2_ok),
        .out_side  (n2_side)
    );

    // Stage 4: products of side cross forward and of side and forward with eye.
    logic                     s4_valid_reg;
    logic [2:0][SF_W-1:0]     s4_sa_reg, s4_sb_reg, s4_sa_next, s4_sb_next;
    logic [2:0][PF_W-1:0]     s4_se_reg, s4_fe_reg, s4_se_next, s4_fe_next;
    logic [2:0][UNIT_W-1:0]   s4_s_reg, s4_f_reg;
    logic                     s4_ok_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s4_sa_next[i] = SF_W'($signed(n2_unit[(i+1)%3]) * $signed(n2_side.fwd[(i+2)%3]));
            s4_sb_next[i] = SF_W'($signed(n2_side.fwd[(i+1)%3]) * $signed(n2_unit[(i+2)%3]));
            s4_se_next[i] = PF_W'($signed(n2_unit[i]) * $signed(n2_side.eye[i]));
            s4_fe_next[i] = PF_W'($signed(n2_side.fwd[i]) * $signed(n2_side.eye[i]));
        end
    end

    // Stage 5: cross differences and dot sums.
    logic                     s5_valid_reg;
    logic [2:0][C2_W-1:0]     s5_c2_reg, s5_c2_next;
    logic [DOT_W-1:0]         s5_se_reg, s5_fe_reg;
    logic [2:0][UNIT_W-1:0]   s5_s_reg, s5_f_reg;
    logic [2:0][COORD_W-1:0]  s4_eye_reg, s5_eye_reg;
    logic                     s5_ok_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            s5_c2_next[i] = C2_W'($signed(s4_sa_reg[i])) - C2_W'($signed(s4_sb_reg[i]));
    end

    // Stage 6: true up vector and the side and forward translation terms.
    logic                     s6_valid_reg;
    logic [2:0][U_W-1:0]      s6_u_reg, s6_u_next;
    logic [T_W-1:0]           s6_t0_reg, s6_t2_reg;
    logic [VEC_W-1:0]         s6_t0_full, s6_t2_full;
    logic [2:0][UNIT_W-1:0]   s6_s_reg, s6_f_reg;
    logic [2:0][COORD_W-1:0]  s6_eye_reg;
    logic                     s6_ok_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            s6_u_next[i] = U_W'(shr_rnd(VEC_W'($signed(s5_c2_reg[i]))));
        s6_t0_full = VEC_W'(-shr_rnd(VEC_W'($signed(s5_se_reg))));
        s6_t2_full = VEC_W'(shr_rnd(VEC_W'($signed(s5_fe_reg))));
    end

    // Stage 7: up times eye. Stage 8: the sum.
    logic                     s7_valid_reg;
    logic [2:0][UE_W-1:0]     s7_ue_reg, s7_ue_next;
    logic [2:0][U_W-1:0]      s7_u_reg, s8_u_reg;
    logic [T_W-1:0]           s7_t0_reg, s7_t2_reg, s8_t0_reg, s8_t2_reg;
    logic [2:0][UNIT_W-1:0]   s7_s_reg, s7_f_reg, s8_s_reg, s8_f_reg;
    logic                     s7_ok_reg, s8_ok_reg;
    logic                     s8_valid_reg;
    logic [UES_W-1:0]         s8_ue_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            s7_ue_next[i] = UE_W'($signed(s6_u_reg[i]) * $signed(s6_eye_reg[i]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s4_valid_reg <= n2_valid;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
            s8_valid_reg <= s7_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_sa_reg  <= s4_sa_next;
            s4_sb_reg  <= s4_sb_next;
            s4_se_reg  <= s4_se_next;
            s4_fe_reg  <= s4_fe_next;
            s4_s_reg   <= n2_unit;
            s4_f_reg   <= n2_side.fwd;
            s4_eye_reg <= n2_side.eye;
            s4_ok_reg  <= n2_ok && !n2_side.bad;

            s5_c2_reg  <= s5_c2_next;
            s5_se_reg  <= DOT_W'($signed(s4_se_reg[0])) + DOT_W'($signed(s4_se_reg[1]))
                          + DOT_W'($signed(s4_se_reg[2]));
            s5_fe_reg  <= DOT_W'($signed(s4_fe_reg[0])) + DOT_W'($signed(s4_fe_reg[1]))
                          + DOT_W'($signed(s4_fe_reg[2]));
            s5_s_reg   <= s4_s_reg;
            s5_f_reg   <= s4_f_reg;
            s5_eye_reg <= s4_eye_reg;
            s5_ok_reg  <= s4_ok_reg;

            s6_u_reg   <= s6_u_next;
            s6_t0_reg  <= s6_t0_full[T_W-1:0];
            s6_t2_reg  <= s6_t2_full[T_W-1:0];
            s6_s_reg   <= s5_s_reg;
            s6_f_reg   <= s5_f_reg;
            s6_eye_reg <= s5_eye_reg;
            s6_ok_reg  <= s5_ok_reg;

            s7_ue_reg  <= s7_ue_next;
            s7_u_reg   <= s6_u_reg;
            s7_t0_reg  <= s6_t0_reg;
            s7_t2_reg  <= s6_t2_reg;
            s7_s_reg   <= s6_s_reg;
            s7_f_reg   <= s6_f_reg;
            s7_ok_reg  <= s6_ok_reg;

            s8_ue_reg  <= UES_W'($signed(s7_ue_reg[0])) + UES_W'($signed(s7_ue_reg[1]))
                          + UES_W'($signed(s7_ue_reg[2]));
            s8_u_reg   <= s7_u_reg;
            s8_t0_reg  <= s7_t0_reg;
            s8_t2_reg  <= s7_t2_reg;
            s8_s_reg   <= s7_s_reg;
            s8_f_reg   <= s7_f_reg;
            s8_ok_reg  <= s7_ok_reg;
        end
    end

    // Final stage: up translation term, saturation and row assembly.
    logic                                 fin_valid_reg;
    logic [2:0][3:0][COORD_W-1:0]         fin_rows_reg, fin_rows_next;
    logic                                 fin_bad_reg;
    logic signed [VEC_W-1:0]              fin_t1;

    always_comb
    begin
        fin_t1 = -shr_rnd(VEC_W'($signed(s8_ue_reg)));
        fin_rows_next = '0;
        if (s8_ok_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                fin_rows_next[ROW_SIDE][i] = sat32(VEC_W'($signed(s8_s_reg[i])));
                fin_rows_next[ROW_UP][i]   = sat32(VEC_W'($signed(s8_u_reg[i])));
                fin_rows_next[ROW_FWD][i]  = sat32(-VEC_W'($signed(s8_f_reg[i])));
            end
            fin_rows_next[ROW_SIDE][3] = sat32(VEC_W'($signed(s8_t0_reg)));
            fin_rows_next[ROW_UP][3]   = sat32(fin_t1);
            fin_rows_next[ROW_FWD][3]  = sat32(VEC_W'($signed(s8_t2_reg)));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin_valid_reg <= 1'b0;
        else if (adv)
            fin_valid_reg <= s8_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fin_rows_reg <= fin_rows_next;
            fin_bad_reg  <= !s8_ok_reg;
        end
    end

    // Row serializer: holds one finished item and shows its rows in order. It takes
    // the next item in the same cycle that its last row is handed over.
    logic                          ser_valid_reg;
    logic [1:0]                    ser_cnt_reg;
    logic [2:0][3:0][COORD_W-1:0]  ser_rows_reg;
    logic                          ser_bad_reg;
    logic                          ser_last;

    assign ser_last = (ser_cnt_reg == ROW_FWD);
    assign ser_free = !ser_valid_reg || (ser_last && rows.ready);
    assign ser_take = fin_valid_reg && ser_free;
    assign adv      = !fin_valid_reg || ser_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_valid_reg <= 1'b0;
            ser_cnt_reg   <= ROW_SIDE;
        end
        else if (ser_take)
        begin
            ser_valid_reg <= 1'b1;
            ser_cnt_reg   <= ROW_SIDE;
        end
        else if (ser_valid_reg && rows.ready)
        begin
            if (ser_last)
                ser_valid_reg <= 1'b0;
            else
                ser_cnt_reg <= ser_cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ser_take)
        begin
            ser_rows_reg <= fin_rows_reg;
            ser_bad_reg  <= fin_bad_reg;
        end
    end

    assign vecs.ready      = adv;
    assign rows.valid      = ser_valid_reg;
    assign rows.row_index  = ser_cnt_reg;
    assign rows.col0       = ser_rows_reg[ser_cnt_reg][0];
    assign rows.col1       = ser_rows_reg[ser_cnt_reg][1];
    assign rows.col2       = ser_rows_reg[ser_cnt_reg][2];
    assign rows.col3       = ser_rows_reg[ser_cnt_reg][3];
    assign rows.degenerate = ser_bad_reg;
    assign rows.last_row   = ser_last;

endmodule

`default_nettype wire

// File: test/lavm_tb_ifs.sv
// Testbench-side definitions: the type of one expected row transaction.
// The channel interfaces themselves come from lavm_ifs in the RTL; nothing is redefined here.
`timescale 1ns / 100ps

package lavm_tb_defs;
    // Per-row expectation of the view matrix.
    typedef struct {
        logic [1:0]  row;
        logic [31:0] c0;
        logic [31:0] c1;
        logic [31:0] c2;
        logic [31:0] c3;
        logic        degen;
        logic        last;
    } view_row_t;
endpackage

// File: test/tb.sv
// Testbench of look_at_view_matrix_unit: a directed table then random look-at cameras,
// each row checked against an in-bench fixed-point predictor. Depends on lavm_pkg, lavm_ifs, lavm_tb_ifs.
`timescale 1ns / 100ps

module tb;
    import lavm_pkg::*;
    import lavm_tb_defs::*;

    // One camera transaction: eye, target, up, plus optional typed-in side row.
    typedef struct {
        logic [31:0] v[9];
        logic        known;
        view_row_t   r0;
    } cam_t;

    logic clk;
    logic rst_n;
    lavm_in_if  vecs();
    lavm_out_if rows();

    look_at_view_matrix_unit u_dut (.clk(clk), .rst_n(rst_n), .vecs(vecs), .rows(rows));

    view_row_t   matrix_rows_q[$];
    int          errors;
    longint      cycles;
    bit          sending_done;
    bit          quiet_send;   // stretch with no gaps on either side
    int          hold_off;     // long receiver hold-off, counted below
    localparam longint CYCLE_LIMIT = 400000;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ---------------- predictor ----------------
    function automatic logic [63:0] magnitude(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v);
        logic [63:0] m;
        m = (magnitude(v) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return v < 0 ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sh7FFFFFFF) return 32'h7FFFFFFF;
        if (v < -64'sh80000000) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // Unit vector with FRAC_BITS fraction bits; returns 0 for a zero vector.
    function automatic bit unit_vector(input logic signed [63:0] v[3],
                                       output logic signed [63:0] r[3]);
        logic [63:0] m[3];
        logic [63:0] mx;
        logic [63:0] sum;
        logic [63:0] len;
        logic [63:0] q;
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = magnitude(v[i]);
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) return 0;
        while (mx >= (64'd1 << 30))
        begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        end
        while (mx < (64'd1 << 29))
        begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        end
        sum = 0;
        for (int i = 0; i < 3; i++) sum = sum + m[i] * m[i];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = ((m[i] << FRAC_BITS) + (len >> 1)) / len;
            r[i] = v[i] < 0 ? -$signed(q) : $signed(q);
        end
        return 1;
    endfunction

    function automatic void cross_product(input logic signed [63:0] a[3],
                                          input logic signed [63:0] b[3],
                                          output logic signed [63:0] r[3]);
        r[0] = a[1] * b[2] - b[1] * a[2];
        r[1] = a[2] * b[0] - b[2] * a[0];
        r[2] = a[0] * b[1] - b[0] * a[1];
    endfunction

    function automatic logic signed [63:0] dot_q(input logic signed [63:0] a[3],
                                                 input logic signed [63:0] b[3]);
        return round_shift(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]);
    endfunction

    // Expected three rows of the view matrix for one camera.
    task automatic predict_view(input logic [31:0] v[9]);
        logic signed [63:0] eye[3], dir[3], up[3], f[3], c[3], s[3], u[3];
        logic signed [63:0] m[3][4];
        bit ok;
        view_row_t r;
        for (int i = 0; i < 3; i++)
        begin
            eye[i] = $signed(v[i]);
            dir[i] = $signed(v[3 + i]) - eye[i];
            up[i]  = $signed(v[6 + i]);
            for (int k = 0; k < 4; k++) m[i][k] = 0;
        end
        ok = unit_vector(dir, f);
        if (ok)
        begin
            cross_product(f, up, c);
            ok = unit_vector(c, s);
        end
        if (ok)
        begin
            cross_product(s, f, c);
            for (int i = 0; i < 3; i++) u[i] = round_shift(c[i]);
            for (int i = 0; i < 3; i++)
            begin
                m[0][i] = s[i];
                m[1][i] = u[i];
                m[2][i] = -f[i];
            end
            m[0][3] = -dot_q(s, eye);
            m[1][3] = -dot_q(u, eye);
            m[2][3] = dot_q(f, eye);
        end
        for (int k = 0; k < 3; k++)
        begin
            r.row = k[1:0];
            r.c0 = clamp32(m[k][0]);
            r.c1 = clamp32(m[k][1]);
            r.c2 = clamp32(m[k][2]);
            r.c3 = clamp32(m[k][3]);
            r.degen = !ok;
            r.last = (k == 2);
            matrix_rows_q.push_back(r);
        end
    endtask

    // ---------------- stimulus ----------------
    cam_t cameras[$];

    function automatic cam_t camera(input int ex, ey, ez, tx, ty, tz, ux, uy, uz);
        cam_t c;
        c.v[0] = ex; c.v[1] = ey; c.v[2] = ez;
        c.v[3] = tx; c.v[4] = ty; c.v[5] = tz;
        c.v[6] = ux; c.v[7] = uy; c.v[8] = uz;
        c.known = 0;
        return c;
    endfunction

    function automatic int rnd_coord();
        case ($urandom_range(0, 9))
            0:       return $urandom;                                  // full range
            1:       return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            2:       return $signed($urandom_range(0, 6)) - 3;          // tiny raw values
            default: return ($signed($urandom_range(0, 2000)) - 1000) <<< 14;
        endcase
    endfunction

    task automatic build_stimulus();
        cam_t c;
        localparam int ONE = 32'h10000;
        // Directed table. Rows marked known carry a side row typed in by hand.
        c = camera(0, 0, 0, 0, 0, -ONE, 0, ONE, 0);           // classic camera at origin
        c.known = 1; c.r0 = '{ROW_SIDE, ONE, 0, 0, 0, 1'b0, 1'b0};
        cameras.push_back(c);
        c = camera(5 * ONE, 5 * ONE, 5 * ONE, 5 * ONE, 5 * ONE, 5 * ONE, 0, ONE, 0);
        c.known = 1; c.r0 = '{ROW_SIDE, 0, 0, 0, 0, 1'b1, 1'b0};   // target equals eye
        cameras.push_back(c);
        c = camera(0, 0, 0, 0, 3 * ONE, 0, 0, ONE, 0);        // forward parallel to up
        c.known = 1; c.r0 = '{ROW_SIDE, 0, 0, 0, 0, 1'b1, 1'b0};
        cameras.push_back(c);
        c = camera(ONE, 2, 3, 4, 5, 6, 0, 0, 0);              // zero up vector
        c.known = 1; c.r0 = '{ROW_SIDE, 0, 0, 0, 0, 1'b1, 1'b0};
        cameras.push_back(c);
        cameras.push_back(camera(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, ONE));
        cameras.push_back(camera(32'h80000000, 32'h80000000, 32'h80000000,
                                 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                 32'h80000000, 32'h7FFFFFFF, 32'h80000000));
        cameras.push_back(camera(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                                 0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000));
        cameras.push_back(camera(0, 0, 0, 1, 0, 0, 0, 0, 1));  // one-ulp forward
        cameras.push_back(camera(0, 0, 0, -1, -1, -1, -1, 1, -1));
        cameras.push_back(camera(32'h40000000, 0, 32'hC0000000, 0, ONE, 0, ONE, 0, 0));
        cameras.push_back(camera(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0,
                                 32'hFFFFFFFF, 0, 32'h55555555));
        cameras.push_back(camera(3 * ONE, 4 * ONE, 0, 0, 0, 0, 0, 0, 32'hAAAAAAAA));
        cameras.push_back(camera(0, 0, 0, ONE, ONE, 0, ONE, ONE, 0));   // parallel, diagonal
        // Random cameras: mostly well formed, a few degenerate on purpose.
        for (int n = 0; n < 460; n++)
        begin
            for (int i = 0; i < 9; i++) c.v[i] = rnd_coord();
            c.known = 0;
            case ($urandom_range(0, 19))
                0: for (int i = 0; i < 3; i++) c.v[3 + i] = c.v[i];
                1: for (int i = 0; i < 3; i++) c.v[6 + i] = c.v[3 + i] - c.v[i];
                2: for (int i = 0; i < 3; i++) c.v[6 + i] = 0;
                default: ;
            endcase
            cameras.push_back(c);
        end
    endtask

    // ---------------- clock-edge processes ----------------
    always @(posedge clk) cycles <= cycles + 1;

    // Sender: changes inputs at the falling edge, checks acceptance at the rising edge.
    initial
    begin
        int idx;
        bit took;
        vecs.valid = 0;
        vecs.eye_x = 0; vecs.eye_y = 0; vecs.eye_z = 0;
        vecs.target_x = 0; vecs.target_y = 0; vecs.target_z = 0;
        vecs.up_x = 0; vecs.up_y = 0; vecs.up_z = 0;
        rows.ready = 0;
        rst_n = 0;
        errors = 0;
        cycles = 0;
        sending_done = 0;
        quiet_send = 0;
        hold_off = 0;
        build_stimulus();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        idx = 0;
        while (idx < cameras.size())
        begin
            @(negedge clk);
            quiet_send = (idx >= 150 && idx < 230);
            if (!quiet_send && $urandom_range(0, 99) < 10)
            begin
                vecs.valid = 0;
                continue;
            end
            {vecs.eye_x, vecs.eye_y, vecs.eye_z} =
                {cameras[idx].v[0], cameras[idx].v[1], cameras[idx].v[2]};
            {vecs.target_x, vecs.target_y, vecs.target_z} =
                {cameras[idx].v[3], cameras[idx].v[4], cameras[idx].v[5]};
            {vecs.up_x, vecs.up_y, vecs.up_z} =
                {cameras[idx].v[6], cameras[idx].v[7], cameras[idx].v[8]};
            vecs.valid = 1;
            // Wait for the rising edge that takes this transaction.
            took = 0;
            while (!took)
            begin
                @(posedge clk);
                took = vecs.ready;
                if (!took) @(negedge clk);
            end
            predict_view(cameras[idx].v);
            if (cameras[idx].known)
                matrix_rows_q[matrix_rows_q.size() - 3] = cameras[idx].r0;
            idx++;
            if (idx == 300) hold_off = 600;  // receiver stalls while the sender keeps going
        end
        @(negedge clk);
        vecs.valid = 0;
        sending_done = 1;
    end

    // Receiver readiness: random stalls, a quiet stretch, and one long hold-off.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_off > 0)
            begin
                rows.ready <= 0;
                hold_off <= hold_off - 1;
            end
            else
                rows.ready <= quiet_send || ($urandom_range(0, 99) >= 10);
        end
    end

    // Row checker.
    always @(posedge clk)
    begin
        view_row_t e;
        if (rst_n && rows.valid && rows.ready)
        begin
            if (matrix_rows_q.size() == 0)
            begin
                $error("unexpected row transaction, row_index %0d", rows.row_index);
                errors++;
            end
            else
            begin
                e = matrix_rows_q.pop_front();
                if (rows.row_index !== e.row)
                begin
                    $error("row_index: expected %0d, got %0d", e.row, rows.row_index);
                    errors++;
                end
                if (rows.col0 !== e.c0)
                begin
                    $error("col0: expected %h, got %h", e.c0, rows.col0);
                    errors++;
                end
                if (rows.col1 !== e.c1)
                begin
                    $error("col1: expected %h, got %h", e.c1, rows.col1);
                    errors++;
                end
                if (rows.col2 !== e.c2)
                begin
                    $error("col2: expected %h, got %h", e.c2, rows.col2);
                    errors++;
                end
                if (rows.col3 !== e.c3)
                begin
                    $error("col3: expected %h, got %h", e.c3, rows.col3);
                    errors++;
                end
                if (rows.degenerate !== e.degen)
                begin
                    $error("degenerate: expected %b, got %b", e.degen, rows.degenerate);
                    errors++;
                end
                if (rows.last_row !== e.last)
                begin
                    $error("last_row: expected %b, got %b", e.last, rows.last_row);
                    errors++;
                end
            end
        end
    end

    // End of run: drain, then a quiet tail for stray rows, or time out.
    initial
    begin
        bit timed_out;
        timed_out = 0;
        wait (sending_done);
        while (matrix_rows_q.size() != 0 && cycles < CYCLE_LIMIT) @(posedge clk);
        if (cycles >= CYCLE_LIMIT)
            timed_out = 1;
        else
            repeat (200) @(posedge clk);
        if (timed_out)
            $display("== FAIL ==");
        else if (errors == 0 && matrix_rows_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog for a stalled sender.
    initial
    begin
        wait (cycles >= CYCLE_LIMIT + 1000);
        $display("== FAIL ==");
        $finish;
    end
endmodule

// File: sim.f
sv/lavm_pkg.sv
sv/lavm_ifs.sv
sv/lavm_norm.sv
sv/look_at_view_matrix_unit.sv
test/lavm_tb_ifs.sv
test/tb.sv
